// ===== design/deq_pkg.sv =====
// shared types and codes for the double-ended queue
package deq_pkg;

  // operation codes carried by an input word
  typedef enum logic [2:0] {
    OP_PUSH_REAR  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_EMIT = 2'd2
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
  } cmd_t;

endpackage

// ===== design/deq_ctrl.sv =====
// controller state machine for the double-ended queue
module deq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output deq_pkg::cmd_t cmd_o
);

  deq_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            emit_ok;

  // output register can take a new word when empty or being drained
  assign emit_ok = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      deq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = deq_pkg::S_EXEC;
        end
      end
      deq_pkg::S_EXEC: begin
        state_d = deq_pkg::S_EMIT;
      end
      deq_pkg::S_EMIT: begin
        if (emit_ok) begin
          state_d = deq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = deq_pkg::S_IDLE;
      end
    endcase
  end

  // outputs and commands
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      deq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      deq_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      deq_pkg::S_EMIT: begin
        cmd_o.emit = emit_ok;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // output valid tracking
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/deq_datapath.sv =====
// ring storage, pointers, count and result register of the double-ended queue
module deq_datapath #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AddrW = $clog2(DEPTH),
  parameter int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  deq_pkg::cmd_t      cmd_i,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] push_value_i,
  output logic signed [31:0] result_value_o,
  output logic [1:0]         status_o,
  output logic [CntW-1:0]    occupancy_o,
  output logic               is_empty_o
);

  localparam logic [AddrW-1:0] LastIdx = AddrW'(DEPTH - 1);
  localparam logic [CntW-1:0]  FullCnt = CntW'(DEPTH);

  logic [31:0] mem [DEPTH];

  deq_pkg::op_e        op_q;
  logic signed [31:0]  val_q;
  logic [AddrW-1:0]    front_q, front_d, rear_q, rear_d;
  logic [CntW-1:0]     count_q, count_d;
  deq_pkg::status_e    st_q, st_d;
  logic                rd_ok_q, rd_ok_d;
  logic [31:0]         rdata_q;
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr, rd_addr;
  logic [AddrW-1:0]    front_prev, front_next, rear_prev;
  logic                full, empty;

  // ring neighbors and occupancy flags
  assign front_next = (front_q == LastIdx) ? '0 : front_q + AddrW'(1);
  assign front_prev = (front_q == '0) ? LastIdx : front_q - AddrW'(1);
  assign rear_prev  = (rear_q == '0) ? LastIdx : rear_q - AddrW'(1);
  assign full       = (count_q == FullCnt);
  assign empty      = (count_q == '0);

  // operation decode and pointer update
  always_comb begin
    front_d = front_q;
    rear_d  = rear_q;
    count_d = count_q;
    wr_en   = 1'b0;
    wr_addr = rear_q;
    rd_addr = front_q;
    st_d    = deq_pkg::ST_OK;
    rd_ok_d = 1'b0;
    if (cmd_i.exec) begin
      unique case (op_q)
        deq_pkg::OP_PUSH_REAR: begin
          if (full) begin
            st_d = deq_pkg::ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = rear_q;
            rear_d  = (rear_q == LastIdx) ? '0 : rear_q + AddrW'(1);
            count_d = count_q + CntW'(1);
          end
        end
        deq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            st_d = deq_pkg::ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = front_prev;
            front_d = front_prev;
            count_d = count_q + CntW'(1);
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            st_d = deq_pkg::ST_EMPTY;
          end else begin
            rd_addr = front_q;
            rd_ok_d = 1'b1;
            front_d = front_next;
            count_d = count_q - CntW'(1);
          end
        end
        deq_pkg::OP_POP_REAR: begin
          if (empty) begin
            st_d = deq_pkg::ST_EMPTY;
          end else begin
            rd_addr = rear_prev;
            rd_ok_d = 1'b1;
            rear_d  = rear_prev;
            count_d = count_q - CntW'(1);
          end
        end
        deq_pkg::OP_PEEK_FRONT: begin
          if (empty) begin
            st_d = deq_pkg::ST_EMPTY;
          end else begin
            rd_addr = front_q;
            rd_ok_d = 1'b1;
          end
        end
        deq_pkg::OP_PEEK_REAR: begin
          if (empty) begin
            st_d = deq_pkg::ST_EMPTY;
          end else begin
            rd_addr = rear_prev;
            rd_ok_d = 1'b1;
          end
        end
        default: begin
          st_d = deq_pkg::ST_OK;
        end
      endcase
    end
  end

  // ring storage with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= val_q;
    end
    if (cmd_i.exec) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      rear_q  <= rear_d;
      count_q <= count_d;
    end
  end

  // captured word, step status and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= deq_pkg::op_e'(operation_i);
      val_q <= push_value_i;
    end
    if (cmd_i.exec) begin
      st_q    <= st_d;
      rd_ok_q <= rd_ok_d;
    end
    if (cmd_i.emit) begin
      result_value_o <= rd_ok_q ? signed'(rdata_q) : 32'sd0;
      status_o       <= st_q;
      occupancy_o    <= count_q;
      is_empty_o     <= (count_q == '0);
    end
  end

endmodule

// ===== design/double_ended_queue.sv =====
// top level of the double-ended queue
// Bounded double-ended queue of DEPTH signed 32-bit values held in a ring
// memory with front and rear pointers and a count. Each input word carries one
// operation (push rear, push front, pop front, pop rear, peek front, peek
// rear) and yields exactly one result word with the value read, a status
// (ok, empty on pop or peek, full on push), the count after the operation and
// an empty flag. Operation codes six and seven change nothing and report ok.
// An input word passes in turn through capture, one ring memory access with
// the pointer and count update, and the load of the output register; the next
// word is accepted in the cycle after that load. The output register holds its
// word until taken, and a word in flight waits in its last step while the
// output register is still occupied. No clearing pass follows reset.
module double_ended_queue #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic [1:0]         status_o,
  output logic [CntW-1:0]    occupancy_o,
  output logic               is_empty_o
);

  deq_pkg::cmd_t cmd;

  // sequencing
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // storage and result
  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .operation_i    (operation_i),
    .push_value_i   (push_value_i),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o),
    .is_empty_o     (is_empty_o)
  );

`ifndef NO_ASSERTIONS
  // count never runs past capacity
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (occupancy_o <= CntW'(DEPTH)))
    else $error("occupancy beyond capacity");

  // a refused push only happens at full capacity
  a_full_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == deq_pkg::ST_FULL) |-> (occupancy_o == CntW'(DEPTH)))
    else $error("full status below capacity");

  // empty status reports an empty queue and a zero value
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == deq_pkg::ST_EMPTY) |->
      (is_empty_o && result_value_o == 32'sd0))
    else $error("empty status with data or nonzero count");

  // ready is low once a word has been accepted, so words are never accepted back to back
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("back-to-back accept");
`endif

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the double-ended queue: directed table, then random traffic
module testbench;
  import deq_pkg::*;

  localparam int unsigned QDEPTH = 16;
  localparam int unsigned RANDOM_WORDS = 1250;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned PRINT_LIMIT = 60;
  localparam int unsigned DIR_ROWS = 26;

  // unused operation codes, which change nothing
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  // bias of the random operation mix
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } op_mix_e;

  // one result word as the queue reports it
  typedef struct packed {
    logic signed [31:0] value;
    status_e            status;
    logic [4:0]         occ;
    logic               empty;
  } deq_result_t;

  // one row of the directed table: operation, value, typed flag, typed result
  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] val;
    logic               typed;
    deq_result_t        res;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         operation = '0;
  logic signed [31:0] push_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  logic [4:0]         occupancy;
  logic               is_empty;

  // predictor copy of the ring
  logic signed [31:0] ring_mem [QDEPTH];
  logic [3:0]         q_front = '0;
  logic [3:0]         q_rear = '0;
  logic [4:0]         q_count = '0;

  deq_result_t pending_results [$];
  dir_row_t    dir_rows [DIR_ROWS];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  double_ended_queue #(.DEPTH(QDEPTH)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .push_value_i   (push_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_value_o (result_value),
    .status_o       (status),
    .occupancy_o    (occupancy),
    .is_empty_o     (is_empty)
  );

  // clock, period 20
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // apply one operation to the predictor ring and return the result it gives
  function automatic deq_result_t deque_apply(input logic [2:0] op,
                                              input logic signed [31:0] val);
    deq_result_t r;
    r.value  = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_REAR, OP_PUSH_FRONT: begin
        if (q_count == QDEPTH) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_REAR) begin
          ring_mem[q_rear] = val;
          q_rear  = q_rear + 4'd1;
          q_count = q_count + 5'd1;
        end else begin
          q_front = q_front - 4'd1;
          ring_mem[q_front] = val;
          q_count = q_count + 5'd1;
        end
      end
      OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
        if (q_count == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_POP_FRONT) begin
          r.value = ring_mem[q_front];
          q_front = q_front + 4'd1;
          q_count = q_count - 5'd1;
        end else if (op == OP_POP_REAR) begin
          q_rear  = q_rear - 4'd1;
          r.value = ring_mem[q_rear];
          q_count = q_count - 5'd1;
        end else if (op == OP_PEEK_FRONT) begin
          r.value = ring_mem[q_front];
        end else begin
          r.value = ring_mem[q_rear - 4'd1];
        end
      end
      default: ;
    endcase
    r.occ   = q_count;
    r.empty = (q_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t: %s differs: got %h, want %h", $realtime, field, got, want);
    mismatches++;
  endtask

  // offer one word, hold it until taken, then log what it should produce
  task automatic send_word(input logic [2:0] op, input logic signed [31:0] val,
                           input logic typed, input deq_result_t typed_res);
    deq_result_t predicted;
    in_valid   <= 1'b1;
    operation  <= op;
    push_value <= val;
    do @(posedge clk_i); while (!in_ready);
    predicted = deque_apply(op, val);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'sh0000_0000;
      3: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_op(input op_mix_e mix);
    int unsigned r;
    int unsigned push_lim;
    int unsigned pop_lim;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin push_lim = 72; pop_lim = 86; end
      MIX_DRAIN: begin push_lim = 25; pop_lim = 82; end
      default:   begin push_lim = 47; pop_lim = 76; end
    endcase
    if (r < 5)
      return r[0] ? OP_UNUSED_6 : OP_UNUSED_7;
    else if (r < push_lim)
      return r[0] ? OP_PUSH_REAR : OP_PUSH_FRONT;
    else if (r < pop_lim)
      return r[0] ? OP_POP_FRONT : OP_POP_REAR;
    else
      return r[0] ? OP_PEEK_FRONT : OP_PEEK_REAR;
  endfunction

  // receiver: rotating ready pattern, redrawn now and then
  logic [15:0] ready_pat = 16'hffff;
  int unsigned pat_age = 0;
  always @(negedge clk_i) begin
    out_ready <= ready_pat[0];
    if (pat_age == 0) begin
      pat_age <= $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0: ready_pat <= 16'hffff;
        1: ready_pat <= 16'($urandom()) | 16'h0001;
        2: ready_pat <= (16'($urandom()) & 16'($urandom())) | 16'h0001;
        default: ready_pat <= 16'($urandom()) | 16'($urandom());
      endcase
    end else begin
      pat_age   <= pat_age - 1;
      ready_pat <= {ready_pat[0], ready_pat[15:1]};
    end
  end

  // result check against the oldest expected word
  always @(posedge clk_i) begin
    deq_result_t want;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, value", result_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (result_value !== want.value)
          report_mismatch("result_value", result_value, want.value);
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (occupancy !== want.occ)
          report_mismatch("occupancy", 32'(occupancy), 32'(want.occ));
        if (is_empty !== want.empty)
          report_mismatch("is_empty", 32'(is_empty), 32'(want.empty));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    op_mix_e     mix;
    int unsigned burst_left;
    int unsigned mix_left;
    int unsigned gap;

    // directed table: op, value, typed, {value, status, occupancy, empty}
    dir_rows[0]  = {OP_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0, ST_EMPTY, 5'd0,  1'b1};
    dir_rows[1]  = {OP_POP_REAR,   32'h0000_0000, 1'b1, 32'h0, ST_EMPTY, 5'd0,  1'b1};
    dir_rows[2]  = {OP_PEEK_FRONT, 32'hffff_ffff, 1'b1, 32'h0, ST_EMPTY, 5'd0,  1'b1};
    dir_rows[3]  = {OP_PEEK_REAR,  32'hffff_ffff, 1'b1, 32'h0, ST_EMPTY, 5'd0,  1'b1};
    dir_rows[4]  = {OP_UNUSED_6,   32'h5a5a_5a5a, 1'b1, 32'h0, ST_OK,    5'd0,  1'b1};
    dir_rows[5]  = {OP_UNUSED_7,   32'ha5a5_a5a5, 1'b1, 32'h0, ST_OK,    5'd0,  1'b1};
    dir_rows[6]  = {OP_PUSH_REAR,  32'h7fff_ffff, 1'b1, 32'h0, ST_OK,    5'd1,  1'b0};
    dir_rows[7]  = {OP_PUSH_FRONT, 32'h8000_0000, 1'b1, 32'h0, ST_OK,    5'd2,  1'b0};
    dir_rows[8]  = {OP_PUSH_FRONT, 32'hffff_ffff, 1'b0, 32'h0, ST_OK,    5'd0,  1'b0};
    dir_rows[9]  = {OP_PUSH_REAR,  32'h0000_0000, 1'b0, 32'h0, ST_OK,    5'd0,  1'b0};
    dir_rows[10] = {OP_PUSH_FRONT, 32'h0000_0001, 1'b0, 32'h0, ST_OK,    5'd0,  1'b0};
    dir_rows[11] = {OP_PUSH_REAR,  32'h8000_0001, 1'b0, 32'h0, ST_OK,    5'd0,  1'b0};
    dir_rows[12] = {OP_PUSH_FRONT, 32'h1234_5678, 1'b0, 32'h0, ST_OK,    5'd0,  1'b0};
    dir_rows[13] = {OP_PUSH_REAR,  32'hdead_beef, 1'b0, 32'h0, ST_OK,    5'd0,  1'b0};
    dir_rows[14] = {OP_PUSH_FRONT, 32'h5555_5555, 1'b0, 32'h0, ST_OK,    5'd0,  1'b0};
    dir_rows[15] = {OP_PUSH_REAR,  32'haaaa_aaaa, 1'b0, 32'h0, ST_OK,    5'd0,  1'b0};
    dir_rows[16] = {OP_PUSH_FRONT, 32'h0f0f_0f0f, 1'b0, 32'h0, ST_OK,    5'd0,  1'b0};
    dir_rows[17] = {OP_PUSH_REAR,  32'hf0f0_f0f0, 1'b0, 32'h0, ST_OK,    5'd0,  1'b0};
    dir_rows[18] = {OP_PUSH_FRONT, 32'h00ff_00ff, 1'b0, 32'h0, ST_OK,    5'd0,  1'b0};
    dir_rows[19] = {OP_PUSH_REAR,  32'hff00_ff00, 1'b0, 32'h0, ST_OK,    5'd0,  1'b0};
    dir_rows[20] = {OP_PUSH_FRONT, 32'h7fff_fffe, 1'b0, 32'h0, ST_OK,    5'd0,  1'b0};
    dir_rows[21] = {OP_PUSH_REAR,  32'h8000_0002, 1'b0, 32'h0, ST_OK,    5'd0,  1'b0};
    dir_rows[22] = {OP_PUSH_REAR,  32'h0000_1234, 1'b1, 32'h0, ST_FULL,  5'd16, 1'b0};
    dir_rows[23] = {OP_PUSH_FRONT, 32'h0000_4321, 1'b1, 32'h0, ST_FULL,  5'd16, 1'b0};
    dir_rows[24] = {OP_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, ST_OK,    5'd0,  1'b0};
    dir_rows[25] = {OP_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, ST_OK,    5'd0,  1'b0};

    // hold reset low, then release it
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed words, back to back
    for (int i = 0; i < DIR_ROWS; i++)
      send_word(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);

    // random words in bursts, with a drifting operation mix
    burst_left = 0;
    mix_left   = 0;
    mix        = MIX_FILL;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (mix_left == 0) begin
        mix_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: mix = MIX_FILL;
          1: mix = MIX_DRAIN;
          default: mix = MIX_BALANCED;
        endcase
      end
      mix_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
                                                 : $urandom_range(1, 24);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      burst_left--;
      send_word(pick_op(mix), pick_value(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain what is still in flight
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
